// ----- sv/rgbaoc_pkg.sv -----
// Shared types and constants of the RGBA source-over compositor.
// Used by every module of the block; depends on nothing else.
package rgbaoc_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // Command address width covers the largest canvas the parameters allow.
   localparam int CMD_ADDR_W = 24;

   // Depth of the command queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BLEND = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_OFF_X  = 2'd2,
      REG_OFF_Y  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [8:0] width;
      logic [8:0] height;
      logic [9:0] off_x;
      logic [9:0] off_y;
   } cfg_type;

   typedef struct packed {
      op_type                kind;
      logic                  in_canvas;
      logic [CMD_ADDR_W-1:0] addr;
      logic [7:0]            alpha;
      logic [7:0]            c;
      logic [7:0]            b;
      logic [7:0]            a;
   } cmd_type;

   // Queue handshake seen by the back part.
   typedef struct packed {
      logic    empty;
      cmd_type head;
   } qhead_type;

endpackage

// ----- sv/rgba_over_compositor_top.sv -----
// Top level of the RGBA source-over compositor: register file and wiring.
// Depends on rgbaoc_pkg, rgbaoc_front, rgbaoc_cmdq and rgbaoc_back.
//
//   Channel   | Handshake            | Payload
//   request   | push / full          | req_op, req_col, req_row, req_chan_*, req_opacity
//   response  | empty / pop          | rsp_out_a/b/c, rsp_out_opacity, rsp_status
//   registers | psel, penable, pwrite| paddr, pwdata, prdata, pready (always high)
//
// The front part classifies a request in the cycle it is taken and places it in a
// four-entry command queue; writes and blends outside the canvas are dropped there.
// The back part serves one command at a time from a one-read, one-write canvas memory:
// a write ends in the idle state, a read in the read state, and a blend with partial
// alpha goes on through the two multiply stages and the eight-step restoring divider.
// Reset is synchronous and clears the queue, the sequencer and the response flag;
// the canvas memory is not cleared and must be filled by software before use.
// A response waiting to be popped holds the back part once the next read reaches
// it, and everything queued behind that read waits with it; requests keep being
// queued until the command queue is full.
module rgba_over_compositor_top
   import rgbaoc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_col,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_chan_a,
   input  logic [7:0]  req_chan_b,
   input  logic [7:0]  req_chan_c,
   input  logic [7:0]  req_opacity,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_a,
   output logic [7:0]  rsp_out_b,
   output logic [7:0]  rsp_out_c,
   output logic [7:0]  rsp_out_opacity,
   output logic        rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type reg_idx;
   logic        cfg_we;
   logic        q_full;
   logic        q_push;
   cmd_type     q_cmd;
   logic        q_pop;
   qhead_type   qhead;

   // Registers sit on word boundaries, so the word index is the register number.
   assign reg_idx = reg_idx_type'(paddr[3:2]);
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         unique case (reg_idx)
            REG_WIDTH:  cfg_in.width  = pwdata[8:0];
            REG_HEIGHT: cfg_in.height = pwdata[8:0];
            REG_OFF_X:  cfg_in.off_x  = pwdata[9:0];
            REG_OFF_Y:  cfg_in.off_y  = pwdata[9:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   // Reads return the stored value; offsets are sign-extended to the bus width.
   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  prdata = {23'd0, cfg_ff.width};
         REG_HEIGHT: prdata = {23'd0, cfg_ff.height};
         REG_OFF_X:  prdata = {{22{cfg_ff.off_x[9]}}, cfg_ff.off_x};
         REG_OFF_Y:  prdata = {{22{cfg_ff.off_y[9]}}, cfg_ff.off_y};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= 9'd256;
         cfg_ff.height <= 9'd256;
         cfg_ff.off_x  <= 10'd0;
         cfg_ff.off_y  <= 10'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgbaoc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .push        (push),
      .full        (full),
      .req_op      (req_op),
      .req_col     (req_col),
      .req_row     (req_row),
      .req_chan_a  (req_chan_a),
      .req_chan_b  (req_chan_b),
      .req_chan_c  (req_chan_c),
      .req_opacity (req_opacity),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   rgbaoc_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .din    (q_cmd),
      .q_full (q_full),
      .pop    (q_pop),
      .qhead  (qhead)
   );

   rgbaoc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .qhead           (qhead),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_a       (rsp_out_a),
      .rsp_out_b       (rsp_out_b),
      .rsp_out_c       (rsp_out_c),
      .rsp_out_opacity (rsp_out_opacity),
      .rsp_status      (rsp_status)
   );

endmodule

// ----- sv/rgbaoc_front.sv -----
// Front part: classifies each request, applies the blend offset and the
// canvas bounds, and forms the memory address. Depends on rgbaoc_pkg.
module rgbaoc_front
   import rgbaoc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_op,
   input  logic [7:0] req_col,
   input  logic [7:0] req_row,
   input  logic [7:0] req_chan_a,
   input  logic [7:0] req_chan_b,
   input  logic [7:0] req_chan_c,
   input  logic [7:0] req_opacity,
   input  cfg_type    cfg,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   op_type             kind;
   logic signed [10:0] x;
   logic signed [10:0] y;
   logic [12:0]        eff_w;
   logic [12:0]        eff_h;
   logic               in_canvas;
   logic [31:0]        lin;

   always_comb begin
      kind = op_type'(req_op);
      if (kind == OP_BLEND) begin
         x = $signed({3'b000, req_col}) + $signed({cfg.off_x[9], cfg.off_x});
         y = $signed({3'b000, req_row}) + $signed({cfg.off_y[9], cfg.off_y});
      end else begin
         x = $signed({3'b000, req_col});
         y = $signed({3'b000, req_row});
      end
      eff_w = (13'(cfg.width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(cfg.width);
      eff_h = (13'(cfg.height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(cfg.height);
      in_canvas = !x[10] && !y[10] && ({3'b000, x[9:0]} < eff_w)
                  && ({3'b000, y[9:0]} < eff_h);
      lin = 32'(y[9:0]) * 32'(MAX_WIDTH) + 32'(x[9:0]);

      q_cmd.kind      = kind;
      q_cmd.in_canvas = in_canvas;
      q_cmd.addr      = lin[CMD_ADDR_W-1:0];
      q_cmd.a         = req_chan_a;
      q_cmd.b         = req_chan_b;
      q_cmd.c         = req_chan_c;
      q_cmd.alpha     = req_opacity;
   end

   // Reads always yield a response; writes and blends outside the canvas
   // and the unused code are taken and dropped here.
   assign q_push = push && !q_full
                   && ((kind == OP_READ)
                       || (in_canvas && ((kind == OP_WRITE) || (kind == OP_BLEND))));
   assign full = q_full;

endmodule

// ----- sv/rgbaoc_cmdq.sv -----
// Short command queue between the front and back parts.
// Depends on rgbaoc_pkg for the command type and depth.
module rgbaoc_cmdq
   import rgbaoc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   din,
   output logic      q_full,
   input  logic      pop,
   output qhead_type qhead
);

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   assign q_full      = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign qhead.empty = (count_ff == '0);
   assign qhead.head  = entry_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("command queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command queue pushed while full");

endmodule

// ----- sv/rgbaoc_back.sv -----
// Back part: canvas memory, source-over arithmetic with a bit-serial
// divider, and the response register. Depends on rgbaoc_pkg.
module rgbaoc_back
   import rgbaoc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  qhead_type  qhead,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_a,
   output logic [7:0] rsp_out_b,
   output logic [7:0] rsp_out_c,
   output logic [7:0] rsp_out_opacity,
   output logic       rsp_status
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RD   = 6'b000010,
      S_MUL1 = 6'b000100,
      S_MUL2 = 6'b001000,
      S_DIV  = 6'b010000,
      S_WB   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic        we;
   logic [AW-1:0] waddr;
   logic [31:0] wdata;

   logic [31:0] dst_ff, dst_in;
   logic [15:0] ps_ff [3];
   logic [15:0] pd_ff [3];
   logic [15:0] dinv_ff;
   logic [7:0]  inv_ff;
   logic [24:0] rem_ff [3];
   logic [24:0] rem_in [3];
   logic [15:0] dv_ff [3];
   logic [15:0] dv_in [3];
   logic [7:0]  quo_ff [3];
   logic [7:0]  quo_in [3];
   logic [2:0]  step_ff, step_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_pix_ff, out_pix_in;
   logic        out_status_ff, out_status_in;
   logic        out_load;

   logic [7:0]  sa;
   logic [24:0] trial [3];
   logic [24:0] shifted [3];
   logic [16:0] asum;

   assign sa = cmd_ff.alpha;

   // The blended alpha is the denominator divided by 255; for values up to
   // 255 * 255, the largest the denominator reaches, that is (d + 1 + (d >> 8)) >> 8.
   assign asum = {1'b0, dv_ff[0]} + 17'd1 + {9'd0, dv_ff[0][15:8]};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shifted[k] = 25'(dv_ff[k]) << step_ff;
         trial[k]   = rem_ff[k] - shifted[k];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      dst_in        = dst_ff;
      q_pop         = 1'b0;
      we            = 1'b0;
      waddr         = cmd_ff.addr[AW-1:0];
      wdata         = dst_ff;
      raddr         = cmd_ff.addr[AW-1:0];
      out_load      = 1'b0;
      out_pix_in    = out_pix_ff;
      out_status_in = out_status_ff;
      step_in       = step_ff;
      for (int k = 0; k < 3; k++) begin
         rem_in[k] = rem_ff[k];
         dv_in[k]  = dv_ff[k];
         quo_in[k] = quo_ff[k];
      end

      unique case (state_ff)
         S_IDLE: begin
            raddr = qhead.head.addr[AW-1:0];
            if (!qhead.empty) begin
               q_pop  = 1'b1;
               cmd_in = qhead.head;
               if (qhead.head.kind == OP_WRITE) begin
                  we    = 1'b1;
                  waddr = qhead.head.addr[AW-1:0];
                  wdata = {qhead.head.alpha, qhead.head.c, qhead.head.b, qhead.head.a};
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (cmd_ff.kind == OP_READ) begin
               if (!out_valid_ff || pop) begin
                  out_load      = 1'b1;
                  out_pix_in    = cmd_ff.in_canvas ? rdata_ff : 32'h0;
                  out_status_in = !cmd_ff.in_canvas;
                  state_in      = S_IDLE;
               end
            end else if (sa == 8'd0) begin
               state_in = S_IDLE;
            end else if (sa == 8'd255) begin
               we       = 1'b1;
               wdata    = {8'hFF, cmd_ff.c, cmd_ff.b, cmd_ff.a};
               state_in = S_IDLE;
            end else begin
               dst_in   = rdata_ff;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            for (int k = 0; k < 3; k++) begin
               rem_in[k] = ({9'd0, ps_ff[k]} << 8) - {9'd0, ps_ff[k]}
                           + 25'(pd_ff[k] * 24'(inv_ff));
            end
            dv_in[0] = 16'(({8'd0, sa} << 8) - {8'd0, sa}) + dinv_ff;
            dv_in[1] = dv_in[0];
            dv_in[2] = dv_in[0];
            step_in  = 3'd7;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int k = 0; k < 3; k++) begin
               if (rem_ff[k] >= shifted[k]) begin
                  rem_in[k] = trial[k];
                  quo_in[k] = quo_ff[k] | (8'd1 << step_ff);
               end
            end
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            we       = 1'b1;
            wdata    = {asum[15:8], quo_ff[2], quo_ff[1], quo_ff[0]};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_MUL2) begin
         for (int k = 0; k < 3; k++) begin
            quo_in[k] = 8'd0;
         end
      end

      out_valid_in = out_load ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      dst_ff        <= dst_in;
      out_pix_ff    <= out_pix_in;
      out_status_ff <= out_status_in;
      step_ff       <= step_in;
      for (int k = 0; k < 3; k++) begin
         rem_ff[k] <= rem_in[k];
         dv_ff[k]  <= dv_in[k];
         quo_ff[k] <= quo_in[k];
      end
      for (int k = 0; k < 3; k++) begin
         ps_ff[k] <= cmd_ff[8*k +: 8] * sa;
         pd_ff[k] <= dst_ff[8*k +: 8] * dst_ff[31:24];
      end
      inv_ff  <= 8'd255 - sa;
      dinv_ff <= dst_ff[31:24] * (8'd255 - sa);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign empty           = !out_valid_ff;
   assign rsp_out_a       = out_pix_ff[7:0];
   assign rsp_out_b       = out_pix_ff[15:8];
   assign rsp_out_c       = out_pix_ff[23:16];
   assign rsp_out_opacity = out_pix_ff[31:24];
   assign rsp_status      = out_status_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || pop))
      else $error("response overwritten before it was taken");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff != 3'd0) |=>
         (state_ff == S_DIV && step_ff == $past(step_ff) - 3'd1))
      else $error("divider step sequence broken");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("command taken while busy");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff == S_IDLE || state_ff == S_RD || state_ff == S_WB))
      else $error("canvas written from an unexpected state");

endmodule

// ----- test/rgba_over_compositor_top_test.sv -----
// Testbench of the RGBA source-over compositor: writes, blends and reads against a
// scoreboard class that keeps its own copy of the canvas. Depends on rgbaoc_pkg and
// rgba_over_compositor_top.
`timescale 1ns / 1ps

module rgba_over_compositor_top_test;
   import rgbaoc_pkg::*;

   // Fields of one read response.
   typedef struct {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] alpha;
      logic       status;
   } pixel_rsp_type;

   // Scoreboard: holds a copy of the canvas and the registers, predicts the
   // response of every read request and checks the responses in order.
   class canvas_scoreboard;
      logic [31:0]   canvas [65536];
      bit            written [65536];
      int unsigned   width_reg;
      int unsigned   height_reg;
      int            off_x;
      int            off_y;
      pixel_rsp_type pending_reads [$];
      int            mismatches;
      int            errors;

      function new();
         width_reg  = 256;
         height_reg = 256;
         off_x      = 0;
         off_y      = 0;
         mismatches = 0;
         errors     = 0;
      endfunction

      function void configure(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_WIDTH:  width_reg  = value[8:0];
            REG_HEIGHT: height_reg = value[8:0];
            REG_OFF_X:  off_x      = $signed(value[9:0]);
            REG_OFF_Y:  off_y      = $signed(value[9:0]);
            default: ;
         endcase
      endfunction

      function bit on_canvas(int x, int y);
         int unsigned w;
         int unsigned h;
         w = (width_reg > 256) ? 256 : width_reg;
         h = (height_reg > 256) ? 256 : height_reg;
         return x >= 0 && y >= 0 && x < w && y < h;
      endfunction

      // Source-over of one pixel in exact integers.
      function logic [31:0] composite(logic [31:0] src, logic [31:0] dst);
         int unsigned sa;
         int unsigned da;
         int unsigned den;
         int unsigned num;
         int unsigned q;
         logic [31:0] res;
         sa = src[31:24];
         da = dst[31:24];
         if (sa == 0) return dst;
         if (sa == 255) return {8'hff, src[23:0]};
         den = 255 * sa + da * (255 - sa);
         for (int k = 0; k < 3; k++) begin
            num = src[8*k +: 8] * sa * 255 + dst[8*k +: 8] * da * (255 - sa);
            q = num / den;
            res[8*k +: 8] = (q > 255) ? 8'hff : q[7:0];
         end
         res[31:24] = 8'(den / 255);
         return res;
      endfunction

      function void note_request(op_type op, int col, int row, logic [31:0] px);
         pixel_rsp_type r;
         int x;
         int y;
         case (op)
            OP_WRITE: begin
               if (on_canvas(col, row)) begin
                  canvas[row * 256 + col]  = px;
                  written[row * 256 + col] = 1;
               end
            end
            OP_BLEND: begin
               x = col + off_x;
               y = row + off_y;
               if (on_canvas(x, y))
                  canvas[y * 256 + x] = composite(px, canvas[y * 256 + x]);
            end
            OP_READ: begin
               if (on_canvas(col, row)) begin
                  r.a      = canvas[row * 256 + col][7:0];
                  r.b      = canvas[row * 256 + col][15:8];
                  r.c      = canvas[row * 256 + col][23:16];
                  r.alpha  = canvas[row * 256 + col][31:24];
                  r.status = 1'b0;
               end else begin
                  r = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
               end
               pending_reads = {pending_reads, r};
            end
            default: ;
         endcase
      endfunction

      function void check_response(pixel_rsp_type got);
         pixel_rsp_type want;
         if (pending_reads.size() == 0) begin
            errors++;
            if (mismatches + errors <= 10)
               $display("unexpected response: %h %h %h %h status %b",
                        got.a, got.b, got.c, got.alpha, got.status);
            return;
         end
         want = pending_reads.pop_front();
         if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
             got.alpha !== want.alpha || got.status !== want.status) begin
            mismatches++;
            if (mismatches + errors <= 10)
               $display("mismatch: expected %h %h %h %h status %b, got %h %h %h %h status %b",
                        want.a, want.b, want.c, want.alpha, want.status,
                        got.a, got.b, got.c, got.alpha, got.status);
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_op = OP_NONE;
   logic [7:0]  req_col = '0;
   logic [7:0]  req_row = '0;
   logic [7:0]  req_chan_a = '0;
   logic [7:0]  req_chan_b = '0;
   logic [7:0]  req_chan_c = '0;
   logic [7:0]  req_opacity = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_out_a;
   logic [7:0]  rsp_out_b;
   logic [7:0]  rsp_out_c;
   logic [7:0]  rsp_out_opacity;
   logic        rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   canvas_scoreboard canvas_sb = new();
   bit  quiet = 0;    // set for the last phase, in which neither side idles
   int  idle_cycles = 0;
   int  coord_pool [8] = '{0, 1, 2, 3, 127, 128, 254, 255};

   // Register settings of each phase of the run.
   int  widths  [8] = '{256, 1,   256,  511, 0, 17,  0,  256};
   int  heights [8] = '{256, 1,   256,  300, 5, 200, 0,  256};
   int  offs_x  [8] = '{0,   0,   -256, -512, 3, 100, 0, 5};
   int  offs_y  [8] = '{0,   0,   256,  511, -3, -100, 0, 7};

   rgba_over_compositor_top DUT (.*);

   always #5 clock = ~clock;

   // Watchdog: counts cycles in which nothing at all is accepted.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[rgba_over_compositor_top] ERROR");
         $finish;
      end
   end

   // Response side: checks every popped response and, unless quiet, stalls in random bursts.
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty)
            canvas_sb.check_response('{rsp_out_a, rsp_out_b, rsp_out_c,
                                       rsp_out_opacity, rsp_status});
         if (reset) begin
            pop <= 1'b0;
         end else if (stall > 0 && !quiet) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
            stall = 0;
            if (!quiet && $urandom_range(0, 7) == 0)
               stall = $urandom_range(1, 19);
         end
      end
   end

   // Writes one register in a setup and an access phase; the caller releases psel.
   task automatic write_reg(reg_idx_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      canvas_sb.configure(idx, value);
   endtask

   // Waits for the block to finish all work, then writes the whole register set.
   task automatic set_canvas(int w, int h, int ox, int oy);
      push <= 1'b0;
      while (canvas_sb.pending_reads.size() != 0) @(posedge clock);
      // A blend gives no response, so let any queued blends run out.
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_OFF_X, ox);
      write_reg(REG_OFF_Y, oy);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one request, waits until it is taken and, unless quiet, then idles at random.
   task automatic send(op_type op, int col, int row, logic [31:0] px);
      push        <= 1'b1;
      req_op      <= op;
      req_col     <= 8'(col);
      req_row     <= 8'(row);
      req_chan_a  <= px[7:0];
      req_chan_b  <= px[15:8];
      req_chan_c  <= px[23:16];
      req_opacity <= px[31:24];
      do @(posedge clock); while (full);
      canvas_sb.note_request(op, col, row, px);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   function automatic int pick_coord();
      if ($urandom_range(0, 3) != 0) return coord_pool[$urandom_range(0, 7)];
      return $urandom_range(0, 255);
   endfunction

   function automatic logic [31:0] random_pixel();
      logic [7:0] alpha;
      case ($urandom_range(0, 3))
         0:       alpha = 8'h00;
         1:       alpha = 8'hff;
         default: alpha = 8'($urandom_range(0, 255));
      endcase
      return {alpha, 24'($urandom())};
   endfunction

   // One random request. Blends and reads that would touch a canvas entry
   // not yet filled are turned into a write of that entry.
   task automatic send_random();
      int          pick;
      int          col;
      int          row;
      int          x;
      int          y;
      logic [31:0] px;
      pick = $urandom_range(0, 99);
      px   = random_pixel();
      col  = pick_coord();
      row  = pick_coord();
      if (pick < 20) begin
         send(OP_WRITE, col, row, px);
      end else if (pick < 60) begin
         // Aim most blends at the pool of often used canvas coordinates.
         if ($urandom_range(0, 3) != 0) begin
            x = pick_coord() - canvas_sb.off_x;
            y = pick_coord() - canvas_sb.off_y;
            if (x >= 0 && x <= 255) col = x;
            if (y >= 0 && y <= 255) row = y;
         end
         x = col + canvas_sb.off_x;
         y = row + canvas_sb.off_y;
         if (canvas_sb.on_canvas(x, y) && !canvas_sb.written[y * 256 + x])
            send(OP_WRITE, x, y, px);
         else
            send(OP_BLEND, col, row, px);
      end else if (pick < 93) begin
         if (canvas_sb.on_canvas(col, row) && !canvas_sb.written[row * 256 + col])
            send(OP_WRITE, col, row, px);
         else
            send(OP_READ, col, row, px);
      end else begin
         send(OP_NONE, col, row, px);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 6) begin
            widths[6]  = $urandom_range(1, 300);
            heights[6] = $urandom_range(1, 300);
            offs_x[6]  = $urandom_range(0, 1023);
            offs_y[6]  = $urandom_range(0, 1023);
         end
         if (phase == 7) quiet = 1;
         set_canvas(widths[phase], heights[phase], offs_x[phase], offs_y[phase]);
         if (phase == 0) begin
            // Extremes of the fields and each kind of blend on the full canvas.
            send(OP_WRITE, 0, 0, 32'h0000_0000);
            send(OP_WRITE, 255, 255, 32'hffff_ffff);
            send(OP_WRITE, 3, 4, 32'h801e_140a);
            send(OP_READ, 0, 0, 32'h0);
            send(OP_READ, 255, 255, 32'hffff_ffff);
            send(OP_BLEND, 3, 4, 32'h00ff_ffff);
            send(OP_READ, 3, 4, 32'h0);
            send(OP_BLEND, 3, 4, 32'h64c8_6432);
            send(OP_READ, 3, 4, 32'h0);
            send(OP_BLEND, 0, 0, 32'h01ff_ffff);
            send(OP_READ, 0, 0, 32'h0);
            send(OP_BLEND, 0, 0, 32'hfe12_3456);
            send(OP_READ, 0, 0, 32'h0);
            send(OP_BLEND, 255, 255, 32'hff00_0000);
            send(OP_READ, 255, 255, 32'h0);
            send(OP_NONE, 255, 255, 32'hffff_ffff);
            send(OP_READ, 255, 255, 32'h0);
         end else if (phase == 1) begin
            // One-pixel canvas: everything but the origin lies outside.
            send(OP_WRITE, 5, 5, 32'h1234_5678);
            send(OP_READ, 5, 5, 32'h0);
            send(OP_BLEND, 0, 1, 32'h8080_8080);
            send(OP_READ, 0, 0, 32'h0);
         end
         repeat (110) send_random();
      end
      push <= 1'b0;

      while (canvas_sb.pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (canvas_sb.mismatches == 0 && canvas_sb.errors == 0)
         $display("[rgba_over_compositor_top] OK");
      else
         $display("[rgba_over_compositor_top] ERROR");
      $finish;
   end

endmodule
